// ===== hdl/sreq_pkg.sv =====
// Shared types and constants for the shared ring event queue.
`timescale 1ns / 1ps
`default_nettype none

package sreq_pkg;

    localparam int DEF_RING_DEPTH = 4096;
    localparam int DEF_DEST_COUNT = 64;

    localparam int DEST_W = 6;
    localparam int DATA_W = 32;
    localparam int PAY_W  = 3 * DATA_W;

    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    typedef enum logic [4:0] {
        ST_CLEAR  = 5'b00001,
        ST_IDLE   = 5'b00010,
        ST_PTR    = 5'b00100,
        ST_SCAN   = 5'b01000,
        ST_RESULT = 5'b10000
    } state_t;

endpackage

`default_nettype wire

// ===== hdl/shared_ring_event_queue.sv =====
// Top level of the shared ring event queue: slot memory, pointer memory and scan sequencer.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one command per transaction:
//   cmd = push stores an event for dest_id at the write head and advances it;
//   cmd = pop searches the ring from dest_id's read pointer for its next event.
//   Output channel (out_valid / out_stall) carries one transaction per pop:
//   found plus the event fields, which read as zero when nothing was found.
//   Push gives no output transaction and leaves the block idle for the next command.
//   Pop: the block reads dest_id's read pointer, then scans slots, examining
//   1 up to RING_DEPTH of them, then enters its result state; the next
//   command is taken once the result has moved to the output register.
//   The scan reads one slot a cycle through the single registered read port
//   of the slot memory. A pop for a destination at or above DEST_COUNT skips
//   the scan and goes straight to the result state with not found.
//   After reset the block clears every slot's valid mark, one slot a cycle,
//   and holds in_stall high until the clearing pass is done.
//   The output register keeps its transaction while out_stall is high; a
//   finished pop waits in its result state until the register frees up.
`timescale 1ns / 1ps
`default_nettype none

module shared_ring_event_queue #(
    parameter int RING_DEPTH = sreq_pkg::DEF_RING_DEPTH,
    parameter int DEST_COUNT = sreq_pkg::DEF_DEST_COUNT
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    output logic                                       in_stall,
    input  wire logic                                  cmd,
    input  wire logic        [sreq_pkg::DEST_W-1:0]    dest_id,
    input  wire logic signed [sreq_pkg::DATA_W-1:0]    kind_in,
    input  wire logic signed [sreq_pkg::DATA_W-1:0]    first_param_in,
    input  wire logic signed [sreq_pkg::DATA_W-1:0]    second_param_in,
    output logic                                       out_valid,
    input  wire logic                                  out_stall,
    output logic                                       found,
    output logic signed      [sreq_pkg::DATA_W-1:0]    kind_out,
    output logic signed      [sreq_pkg::DATA_W-1:0]    first_param_out,
    output logic signed      [sreq_pkg::DATA_W-1:0]    second_param_out
);

    import sreq_pkg::*;

    localparam int AW     = $clog2(RING_DEPTH);
    localparam int PW     = $clog2(DEST_COUNT);
    localparam int META_W = DEST_W + 1;
    localparam logic [AW-1:0] LAST_SLOT  = AW'(RING_DEPTH - 1);
    localparam logic [31:0]   DEST_LIMIT = 32'(DEST_COUNT);

    function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] pos);
        logic [AW-1:0] nxt;
        if (pos == LAST_SLOT)
        begin
            nxt = '0;
        end
        else
        begin
            nxt = pos + 1'b1;
        end
        return nxt;
    endfunction

    // Storage: {valid, dest} per slot, event payload per slot, read pointer per destination
    logic [META_W-1:0] meta_mem [RING_DEPTH];
    logic [PAY_W-1:0]  pay_mem  [RING_DEPTH];
    logic [AW-1:0]     ptr_mem  [DEST_COUNT];

    logic [META_W-1:0]     meta_rd_reg;
    logic [PAY_W-1:0]      pay_rd_reg;
    logic [AW-1:0]         ptr_rd_reg;

    state_t                state_reg;
    state_t                state_next;
    logic [AW-1:0]         head_reg;
    logic [AW-1:0]         clr_cnt_reg;
    logic [DEST_COUNT-1:0] ptr_vld_reg;
    logic                  out_valid_reg;

    logic [DEST_W-1:0]     dest_reg;
    logic [PW-1:0]         dest_idx_reg;
    logic [AW-1:0]         scan_addr_reg;
    logic [AW-1:0]         chk_addr_reg;
    logic [AW-1:0]         chk_cnt_reg;
    logic                  res_found_reg;
    logic [PAY_W-1:0]      res_pay_reg;
    logic                  out_found_reg;
    logic [PAY_W-1:0]      out_pay_reg;

    logic                  in_accept;
    logic                  dest_ok;
    logic                  push_go;
    logic                  pop_go;
    logic [AW-1:0]         start_ptr;
    logic [AW-1:0]         head_after;
    logic                  slot_hit;
    logic                  scan_miss_end;
    logic                  res_load;
    logic                  out_free;
    logic                  meta_we;
    logic [AW-1:0]         meta_waddr;
    logic [META_W-1:0]     meta_wdata;
    logic [AW-1:0]         slot_raddr;

    // Handshake and command decode
    assign in_stall   = (state_reg != ST_IDLE);
    assign in_accept  = in_valid && !in_stall;
    assign dest_ok    = (32'(dest_id) < DEST_LIMIT);
    assign push_go    = in_accept && (cmd == CMD_PUSH) && dest_ok;
    assign pop_go     = in_accept && (cmd == CMD_POP);
    assign head_after = ring_next(head_reg);
    assign out_free   = !out_valid_reg || !out_stall;

    // Scan start point: a destination never popped from starts at slot zero
    assign start_ptr = ptr_vld_reg[dest_idx_reg] ? ptr_rd_reg : '0;

    // Compare the slot read last cycle against the destination being popped
    assign slot_hit      = (state_reg == ST_SCAN) && meta_rd_reg[META_W-1]
                           && (meta_rd_reg[DEST_W-1:0] == dest_reg);
    assign scan_miss_end = (state_reg == ST_SCAN) && !slot_hit
                           && (chk_cnt_reg == LAST_SLOT);
    assign res_load      = slot_hit || scan_miss_end || (pop_go && !dest_ok);

    // Slot memory port selection
    assign slot_raddr = (state_reg == ST_PTR) ? start_ptr : scan_addr_reg;

    always_comb
    begin
        meta_we    = 1'b0;
        meta_waddr = head_reg;
        meta_wdata = {1'b1, dest_id};
        if (state_reg == ST_CLEAR)
        begin
            meta_we    = 1'b1;
            meta_waddr = clr_cnt_reg;
            meta_wdata = '0;
        end
        else if (push_go)
        begin
            meta_we = 1'b1;
        end
        else if (slot_hit)
        begin
            meta_we    = 1'b1;
            meta_waddr = chk_addr_reg;
            meta_wdata = {1'b0, dest_reg};
        end
    end

    // Memories: one write, one registered read each
    always_ff @(posedge clk)
    begin
        if (meta_we)
        begin
            meta_mem[meta_waddr] <= meta_wdata;
        end
        meta_rd_reg <= meta_mem[slot_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (push_go)
        begin
            pay_mem[head_reg] <= {kind_in, first_param_in, second_param_in};
        end
        pay_rd_reg <= pay_mem[slot_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (slot_hit)
        begin
            ptr_mem[dest_idx_reg] <= ring_next(chk_addr_reg);
        end
        ptr_rd_reg <= ptr_mem[PW'(dest_id)];
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_cnt_reg == LAST_SLOT)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (pop_go)
                begin
                    state_next = dest_ok ? ST_PTR : ST_RESULT;
                end
            end
            ST_PTR:
            begin
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (slot_hit || scan_miss_end)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            head_reg      <= '0;
            clr_cnt_reg   <= '0;
            ptr_vld_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_cnt_reg <= ring_next(clr_cnt_reg);
            end
            if (push_go)
            begin
                head_reg <= head_after;
            end
            if (slot_hit)
            begin
                ptr_vld_reg[dest_idx_reg] <= 1'b1;
            end
            if ((state_reg == ST_RESULT) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Scan and result datapath
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            dest_reg     <= dest_id;
            dest_idx_reg <= PW'(dest_id);
        end
        if (state_reg == ST_PTR)
        begin
            chk_addr_reg  <= start_ptr;
            scan_addr_reg <= ring_next(start_ptr);
            chk_cnt_reg   <= '0;
        end
        else if (state_reg == ST_SCAN)
        begin
            chk_addr_reg  <= scan_addr_reg;
            scan_addr_reg <= ring_next(scan_addr_reg);
            chk_cnt_reg   <= chk_cnt_reg + 1'b1;
        end
        if (res_load)
        begin
            res_found_reg <= slot_hit;
            res_pay_reg   <= slot_hit ? pay_rd_reg : '0;
        end
        if ((state_reg == ST_RESULT) && out_free)
        begin
            out_found_reg <= res_found_reg;
            out_pay_reg   <= res_pay_reg;
        end
    end

    assign out_valid        = out_valid_reg;
    assign found            = out_found_reg;
    assign kind_out         = out_pay_reg[3*DATA_W-1:2*DATA_W];
    assign first_param_out  = out_pay_reg[2*DATA_W-1:DATA_W];
    assign second_param_out = out_pay_reg[DATA_W-1:0];

    // Checks
    a_hit_reports_found: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && slot_hit) |=> (state_reg == ST_RESULT && res_found_reg))
        else $error("slot hit did not produce a found result");

    a_miss_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !found) |-> (kind_out == '0 && first_param_out == '0
                                   && second_param_out == '0))
        else $error("not-found transaction carries nonzero payload");

    a_out_from_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == ST_RESULT))
        else $error("output transaction raised outside the result state");

    a_push_advances_head: assert property (@(posedge clk) disable iff (!rst_n)
        push_go |=> (head_reg == $past(head_after)))
        else $error("write head did not advance by one slot on push");

    a_clear_covers_ring: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && $past(state_reg == ST_CLEAR))
            |-> $past(clr_cnt_reg == LAST_SLOT))
        else $error("clearing pass ended before the last slot");

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
// Testbench for the shared ring event queue: push/pop traffic checked against a ring predictor.
`timescale 1ns / 1ps

module tb_top;
    import sreq_pkg::*;

    localparam int RING_DEPTH   = DEF_RING_DEPTH;
    localparam int DEST_COUNT   = DEF_DEST_COUNT;
    localparam int RANDOM_ITEMS = 1750;
    localparam int HOLD_CYCLES  = 2500;
    localparam int PRINT_CAP    = 100;

    typedef logic signed [DATA_W-1:0] word_t;

    localparam word_t WORD_MIN   = 32'sh8000_0000;
    localparam word_t WORD_MAX   = 32'sh7fff_ffff;
    localparam word_t WORD_ONES  = 32'shffff_ffff;
    localparam word_t WORD_ALT_A = 32'sh5555_5555;
    localparam word_t WORD_ALT_B = 32'shaaaa_aaaa;

    typedef struct {
        logic  hit;
        word_t kind;
        word_t first;
        word_t second;
    } pop_result_t;

    logic              clk             = 1'b0;
    logic              rst_n           = 1'b0;
    logic              in_valid        = 1'b0;
    logic              in_stall;
    logic              cmd             = CMD_PUSH;
    logic [DEST_W-1:0] dest_id         = '0;
    word_t             kind_in         = '0;
    word_t             first_param_in  = '0;
    word_t             second_param_in = '0;
    logic              out_valid;
    logic              out_stall       = 1'b0;
    logic              found;
    word_t             kind_out;
    word_t             first_param_out;
    word_t             second_param_out;

    // Ring image kept by the testbench
    logic              ring_live   [RING_DEPTH];
    logic [DEST_W-1:0] ring_owner  [RING_DEPTH];
    word_t             ring_kind   [RING_DEPTH];
    word_t             ring_first  [RING_DEPTH];
    word_t             ring_second [RING_DEPTH];
    int                ring_head;
    int                dest_cursor [DEST_COUNT];
    int                live_count  [DEST_COUNT];

    pop_result_t expected_pops [$];
    int          mismatches    = 0;
    bit          no_gaps       = 1'b0;
    int          hold_request  = 0;

    shared_ring_event_queue dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .cmd              (cmd),
        .dest_id          (dest_id),
        .kind_in          (kind_in),
        .first_param_in   (first_param_in),
        .second_param_in  (second_param_in),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .found            (found),
        .kind_out         (kind_out),
        .first_param_out  (first_param_out),
        .second_param_out (second_param_out)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    initial
    begin
        #240_000_000;
        $display("status: fail");
        $finish;
    end

    task automatic report_mismatch(input string what);
        if (mismatches < PRINT_CAP)
        begin
            $display("[%0t] MISMATCH: %s", $realtime, what);
        end
        mismatches++;
    endtask

    function automatic int ring_next(input int idx);
        return (idx == RING_DEPTH - 1) ? 0 : idx + 1;
    endfunction

    // Apply one accepted transaction to the ring image; queue the result of a pop
    task automatic apply_to_ring(input logic c, input logic [DEST_W-1:0] d,
                                 input word_t k, input word_t f, input word_t s);
        pop_result_t res;
        int          pos;
        res.hit    = 1'b0;
        res.kind   = '0;
        res.first  = '0;
        res.second = '0;
        if (c == CMD_PUSH)
        begin
            if (int'(d) < DEST_COUNT)
            begin
                // Overwrite the head slot, losing whatever event was there
                if (ring_live[ring_head])
                begin
                    live_count[ring_owner[ring_head]]--;
                end
                ring_live[ring_head]   = 1'b1;
                ring_owner[ring_head]  = d;
                ring_kind[ring_head]   = k;
                ring_first[ring_head]  = f;
                ring_second[ring_head] = s;
                live_count[d]++;
                ring_head = ring_next(ring_head);
            end
        end
        else
        begin
            if (int'(d) < DEST_COUNT)
            begin
                // Search circularly from the cursor for the first live slot of this destination
                pos = dest_cursor[d];
                for (int i = 0; i < RING_DEPTH; i++)
                begin
                    if (ring_live[pos] && ring_owner[pos] == d)
                    begin
                        ring_live[pos] = 1'b0;
                        res.hit        = 1'b1;
                        res.kind       = ring_kind[pos];
                        res.first      = ring_first[pos];
                        res.second     = ring_second[pos];
                        dest_cursor[d] = ring_next(pos);
                        live_count[d]--;
                        break;
                    end
                    pos = ring_next(pos);
                end
            end
            expected_pops.push_back(res);
        end
    endtask

    // Offer one transaction, hold it until accepted, then update the ring image
    task automatic send_item(input logic c, input logic [DEST_W-1:0] d,
                             input word_t k, input word_t f, input word_t s);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid        <= 1'b1;
        cmd             <= c;
        dest_id         <= d;
        kind_in         <= k;
        first_param_in  <= f;
        second_param_in <= s;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        apply_to_ring(c, d, k, f, s);
    endtask

    function automatic word_t pick_word();
        case ($urandom_range(0, 11))
            0:       return WORD_MIN;
            1:       return WORD_MAX;
            2:       return '0;
            3:       return WORD_ONES;
            default: return word_t'($urandom);
        endcase
    endfunction

    task automatic push_for(input logic [DEST_W-1:0] d);
        send_item(CMD_PUSH, d, pick_word(), pick_word(), pick_word());
    endtask

    task automatic pop_for(input logic [DEST_W-1:0] d);
        send_item(CMD_POP, d, pick_word(), pick_word(), pick_word());
    endtask

    // First destination at or after start that has a live event, -1 when the ring is empty
    function automatic int live_dest_near(input int start);
        int d;
        for (int i = 0; i < DEST_COUNT; i++)
        begin
            d = (start + i) % DEST_COUNT;
            if (live_count[d] > 0)
            begin
                return d;
            end
        end
        return -1;
    endfunction

    task automatic test_directed();
        // Empty ring: the search covers every slot and finds nothing
        pop_for(6'd0);
        send_item(CMD_PUSH, 6'd0,  WORD_MIN,   WORD_MAX,   '0);
        send_item(CMD_PUSH, 6'd63, WORD_MAX,   WORD_MIN,   WORD_ONES);
        send_item(CMD_PUSH, 6'd0,  WORD_ONES,  '0,         WORD_MIN);
        send_item(CMD_PUSH, 6'd21, WORD_ALT_A, WORD_ALT_B, WORD_ALT_A);
        send_item(CMD_PUSH, 6'd42, WORD_ALT_B, WORD_ALT_A, WORD_ALT_B);
        // Skip a slot owned by another destination
        pop_for(6'd63);
        // Drain destination 0, then search past the end of the ring and come back empty
        pop_for(6'd0);
        pop_for(6'd0);
        pop_for(6'd0);
        pop_for(6'd63);
        pop_for(6'd42);
        pop_for(6'd21);
        // Back-to-back transactions with no idle cycles
        no_gaps = 1'b1;
        repeat (3) push_for(6'd7);
        repeat (3) pop_for(6'd7);
        no_gaps = 1'b0;
    endtask

    task automatic test_random_mix();
        int base;
        int roll;
        int d;
        base = $urandom_range(0, DEST_COUNT - 1);
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            // Move the busy destinations around now and then
            if (n % 200 == 0)
            begin
                base = $urandom_range(0, DEST_COUNT - 1);
            end
            no_gaps = (n % 170) < 25;
            roll    = $urandom_range(0, 99);
            d       = live_dest_near((base + $urandom_range(0, 5)) % DEST_COUNT);
            if (roll >= 97)
            begin
                pop_for(DEST_W'($urandom_range(0, DEST_COUNT - 1)));
            end
            else if (roll < 50 || d < 0)
            begin
                push_for(DEST_W'((base + $urandom_range(0, 5)) % DEST_COUNT));
            end
            else
            begin
                pop_for(DEST_W'(d));
            end
        end
        no_gaps = 1'b0;
    endtask

    task automatic test_backpressure();
        // Drain destination 33 so it has no live events left
        while (live_count[33] > 0) pop_for(6'd33);
        repeat (6) push_for(6'd33);
        // Hold off the result side while pops keep coming, so the block backs up
        hold_request = HOLD_CYCLES;
        repeat (6) pop_for(6'd33);
        repeat (4) push_for(6'd34);
    endtask

    // Result side: random stalls per transaction, plus one long hold when requested
    initial
    begin
        int pause;
        wait (rst_n);
        forever
        begin
            if (hold_request > 0)
            begin
                pause        = hold_request;
                hold_request = 0;
                out_stall <= 1'b1;
                repeat (pause) @(posedge clk);
            end
            pause = no_gaps ? 0 : $urandom_range(0, 4);
            if (pause > 0)
            begin
                out_stall <= 1'b1;
                repeat (pause) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid && hold_request == 0) @(posedge clk);
        end
    end

    // Compare each accepted result with the oldest expected pop
    always @(posedge clk)
    begin
        pop_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_pops.size() == 0)
            begin
                report_mismatch("result transaction with no pop outstanding");
            end
            else
            begin
                want = expected_pops.pop_front();
                if (found !== want.hit)
                begin
                    report_mismatch($sformatf("found %0b, expected %0b", found, want.hit));
                end
                if (kind_out !== want.kind)
                begin
                    report_mismatch($sformatf("kind_out %h, expected %h", kind_out, want.kind));
                end
                if (first_param_out !== want.first)
                begin
                    report_mismatch($sformatf("first_param_out %h, expected %h",
                                              first_param_out, want.first));
                end
                if (second_param_out !== want.second)
                begin
                    report_mismatch($sformatf("second_param_out %h, expected %h",
                                              second_param_out, want.second));
                end
            end
        end
    end

    initial
    begin
        for (int i = 0; i < RING_DEPTH; i++)
        begin
            ring_live[i] = 1'b0;
        end
        for (int i = 0; i < DEST_COUNT; i++)
        begin
            dest_cursor[i] = 0;
            live_count[i]  = 0;
        end
        ring_head = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_random_mix();
        test_backpressure();

        // Let every outstanding pop come back before reporting the status
        in_valid <= 1'b0;
        while (expected_pops.size() != 0) @(posedge clk);
        repeat (16) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/sreq_pkg.sv
hdl/shared_ring_event_queue.sv
verif/tb_top.sv
